// ----- src/ksh_pkg.sv -----
`timescale 1ns / 1ps

package ksh_pkg;

   localparam int KEY_W   = 64;
   localparam int COUNT_W = 32;
   localparam int CLASS_W = 2;
   localparam int OP_W    = 2;
   localparam int RIDX_W  = 8;
   localparam int EIDX_W  = 8;
   localparam int USED_W  = 9;

   localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
   localparam logic [OP_W-1:0] OP_READ   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [CLASS_W-1:0] CLASS_NAMED   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_UNKNOWN = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_SPARE   = 2'd3;

   typedef enum logic [1:0] {
      FIN_NOP,
      FIN_RECORD,
      FIN_READ,
      FIN_CLEAR
   } fin_kind_type;

   typedef struct packed {
      logic         load;
      logic         scan_step;
      logic         read_issue;
      logic         finish;
      fin_kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_done;
      logic out_free;
   } status_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + COUNT_W'(1);
   endfunction

endpackage

// ----- src/keyed_sample_histogram.sv -----
// A record searches the table linearly, one entry read per cycle through the single read
//   port, and a read issues one entry read before its result;
//   clear, other codes and a record while disabled take 1 cycle.
// Words are taken one at a time; the next word is taken the cycle after the result enters
//   the output register, and a result waits to enter it while the one before it is stalled.
// Reset: synchronous, clears the table fill, total, enable and handshake state.
`timescale 1ns / 1ps

module keyed_sample_histogram #(
   parameter int ENTRIES = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ksh_pkg::OP_W-1:0]    req_opcode,
   input  logic [ksh_pkg::CLASS_W-1:0] req_symbol_class,
   input  logic [ksh_pkg::KEY_W-1:0]   req_symbol_key,
   input  logic [ksh_pkg::RIDX_W-1:0]  req_read_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ksh_pkg::EIDX_W-1:0]  rsp_entry_index,
   output logic                        rsp_entry_valid,
   output logic                        rsp_was_allocated,
   output logic                        rsp_dropped,
   output logic [ksh_pkg::KEY_W-1:0]   rsp_entry_key,
   output logic [ksh_pkg::CLASS_W-1:0] rsp_entry_class,
   output logic [ksh_pkg::COUNT_W-1:0] rsp_entry_count,
   output logic [ksh_pkg::COUNT_W-1:0] rsp_total_count,
   output logic [ksh_pkg::USED_W-1:0]  rsp_entries_used,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic                        csr_wdata
);

   ksh_pkg::cmd_type    cmd;
   ksh_pkg::status_type status;

   ksh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

   ksh_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_symbol_class  (req_symbol_class),
      .req_symbol_key    (req_symbol_key),
      .req_read_index    (req_read_index),
      .cmd               (cmd),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_was_allocated (rsp_was_allocated),
      .rsp_dropped       (rsp_dropped),
      .rsp_entry_key     (rsp_entry_key),
      .rsp_entry_class   (rsp_entry_class),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_total_count   (rsp_total_count),
      .rsp_entries_used  (rsp_entries_used)
   );

endmodule

// ----- src/ksh_ctrl.sv -----
`timescale 1ns / 1ps

module ksh_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ksh_pkg::OP_W-1:0] req_opcode,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_wdata,
   output ksh_pkg::cmd_type         cmd,
   input  ksh_pkg::status_type      status
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_RD_ISSUE,
      S_FINISH
   } state_type;

   state_type             state_ff, state_in;
   ksh_pkg::fin_kind_type kind_ff, kind_in;
   logic                  enable_ff, enable_in;
   logic                  accept;

   assign req_stall = reset || (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      enable_in  = csr_valid ? csr_wdata : enable_ff;
      cmd        = '0;
      cmd.kind   = kind_ff;
      cmd.load   = accept;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  ksh_pkg::OP_RECORD: begin
                     if (enable_ff) begin
                        kind_in  = ksh_pkg::FIN_RECORD;
                        state_in = S_SCAN;
                     end else begin
                        kind_in  = ksh_pkg::FIN_NOP;
                        state_in = S_FINISH;
                     end
                  end
                  ksh_pkg::OP_READ: begin
                     kind_in  = ksh_pkg::FIN_READ;
                     state_in = S_RD_ISSUE;
                  end
                  ksh_pkg::OP_CLEAR: begin
                     kind_in  = ksh_pkg::FIN_CLEAR;
                     state_in = S_FINISH;
                  end
                  default: begin
                     kind_in  = ksh_pkg::FIN_NOP;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // stop reading once the compare stage holds the match
            cmd.scan_step = !status.hit;
            if (status.hit || status.scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_RD_ISSUE: begin
            cmd.read_issue = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         kind_ff   <= ksh_pkg::FIN_NOP;
         enable_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         kind_ff   <= kind_in;
         enable_ff <= enable_in;
      end
   end

endmodule

// ----- src/ksh_datapath.sv -----
`timescale 1ns / 1ps

module ksh_datapath #(
   parameter int ENTRIES = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ksh_pkg::CLASS_W-1:0] req_symbol_class,
   input  logic [ksh_pkg::KEY_W-1:0]   req_symbol_key,
   input  logic [ksh_pkg::RIDX_W-1:0]  req_read_index,
   input  ksh_pkg::cmd_type            cmd,
   output ksh_pkg::status_type         status,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ksh_pkg::EIDX_W-1:0]  rsp_entry_index,
   output logic                        rsp_entry_valid,
   output logic                        rsp_was_allocated,
   output logic                        rsp_dropped,
   output logic [ksh_pkg::KEY_W-1:0]   rsp_entry_key,
   output logic [ksh_pkg::CLASS_W-1:0] rsp_entry_class,
   output logic [ksh_pkg::COUNT_W-1:0] rsp_entry_count,
   output logic [ksh_pkg::COUNT_W-1:0] rsp_total_count,
   output logic [ksh_pkg::USED_W-1:0]  rsp_entries_used
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int RW    = (CNT_W > ksh_pkg::RIDX_W) ? CNT_W : ksh_pkg::RIDX_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(ENTRIES);

   // entry stores
   logic [ksh_pkg::KEY_W-1:0]   key_mem   [ENTRIES];
   logic [ksh_pkg::CLASS_W-1:0] class_mem [ENTRIES];
   logic [ksh_pkg::COUNT_W-1:0] count_mem [ENTRIES];

   // latched request, normalized
   logic [ksh_pkg::CLASS_W-1:0] op_cls_ff;
   logic [ksh_pkg::KEY_W-1:0]   op_key_ff;
   logic [ksh_pkg::RIDX_W-1:0]  op_ridx_ff;
   logic [ksh_pkg::CLASS_W-1:0] norm_cls;

   logic [CNT_W-1:0]            used_ff;
   logic [ksh_pkg::COUNT_W-1:0] total_ff;

   // scan pipeline
   logic [CNT_W-1:0]            scan_ptr_ff;
   logic [IDX_W-1:0]            cmp_ptr_ff;
   logic                        rd_vld_ff;
   logic [ksh_pkg::KEY_W-1:0]   rd_key_ff;
   logic [ksh_pkg::CLASS_W-1:0] rd_class_ff;
   logic [ksh_pkg::COUNT_W-1:0] rd_count_ff;
   logic                        unk_found_ff;
   logic [IDX_W-1:0]            unk_idx_ff;
   logic [ksh_pkg::COUNT_W-1:0] unk_count_ff;

   logic                        scan_issue;
   logic                        issue;
   logic [IDX_W-1:0]            rd_addr;
   logic [RW-1:0]               ridx_wide;
   logic                        in_range;
   logic                        match;
   logic                        full;

   // result and update values
   logic [ksh_pkg::EIDX_W-1:0]  o_idx;
   logic                        o_valid;
   logic                        o_alloc;
   logic                        o_drop;
   logic [ksh_pkg::KEY_W-1:0]   o_key;
   logic [ksh_pkg::CLASS_W-1:0] o_class;
   logic [ksh_pkg::COUNT_W-1:0] o_count;
   logic [CNT_W-1:0]            used_in;
   logic [ksh_pkg::COUNT_W-1:0] total_in;
   logic                        meta_we;
   logic                        count_we;
   logic [IDX_W-1:0]            waddr;
   logic [ksh_pkg::COUNT_W-1:0] wcount;

   logic                        rsp_valid_ff;
   logic [ksh_pkg::EIDX_W-1:0]  rsp_idx_ff;
   logic                        rsp_evalid_ff;
   logic                        rsp_alloc_ff;
   logic                        rsp_drop_ff;
   logic [ksh_pkg::KEY_W-1:0]   rsp_key_ff;
   logic [ksh_pkg::CLASS_W-1:0] rsp_class_ff;
   logic [ksh_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [ksh_pkg::COUNT_W-1:0] rsp_total_ff;
   logic [ksh_pkg::USED_W-1:0]  rsp_used_ff;

   assign norm_cls = (req_symbol_class == ksh_pkg::CLASS_SPARE) ?
                     ksh_pkg::CLASS_UNKNOWN : req_symbol_class;

   assign ridx_wide  = RW'(op_ridx_ff);
   assign in_range   = ridx_wide < RW'(used_ff);
   assign full       = used_ff == FULL_COUNT;
   assign scan_issue = cmd.scan_step && (scan_ptr_ff < used_ff);
   assign issue      = scan_issue || cmd.read_issue;
   assign rd_addr    = cmd.read_issue ? ridx_wide[IDX_W-1:0] : scan_ptr_ff[IDX_W-1:0];

   assign match = rd_vld_ff && (rd_class_ff == op_cls_ff) &&
                  ((op_cls_ff != ksh_pkg::CLASS_NAMED) || (rd_key_ff == op_key_ff));

   assign status.hit       = match;
   assign status.scan_done = !rd_vld_ff && (scan_ptr_ff >= used_ff);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      o_idx    = '0;
      o_valid  = 1'b0;
      o_alloc  = 1'b0;
      o_drop   = 1'b0;
      o_key    = '0;
      o_class  = '0;
      o_count  = '0;
      used_in  = used_ff;
      total_in = total_ff;
      meta_we  = 1'b0;
      count_we = 1'b0;
      waddr    = cmp_ptr_ff;
      wcount   = ksh_pkg::sat_inc(rd_count_ff);
      case (cmd.kind)
         ksh_pkg::FIN_RECORD: begin
            total_in = ksh_pkg::sat_inc(total_ff);
            if (match) begin
               count_we = 1'b1;
               o_idx    = ksh_pkg::EIDX_W'(cmp_ptr_ff);
               o_valid  = 1'b1;
               o_key    = rd_key_ff;
               o_class  = rd_class_ff;
               o_count  = wcount;
            end else if (!full) begin
               meta_we  = 1'b1;
               count_we = 1'b1;
               waddr    = used_ff[IDX_W-1:0];
               wcount   = ksh_pkg::COUNT_W'(1);
               used_in  = used_ff + CNT_W'(1);
               o_idx    = ksh_pkg::EIDX_W'(used_ff);
               o_valid  = 1'b1;
               o_alloc  = 1'b1;
               o_key    = op_key_ff;
               o_class  = op_cls_ff;
               o_count  = ksh_pkg::COUNT_W'(1);
            end else if (unk_found_ff) begin
               // fold into the first unknown entry
               count_we = 1'b1;
               waddr    = unk_idx_ff;
               wcount   = ksh_pkg::sat_inc(unk_count_ff);
               o_idx    = ksh_pkg::EIDX_W'(unk_idx_ff);
               o_valid  = 1'b1;
               o_class  = ksh_pkg::CLASS_UNKNOWN;
               o_count  = ksh_pkg::sat_inc(unk_count_ff);
            end else begin
               o_drop = 1'b1;
            end
         end
         ksh_pkg::FIN_READ: begin
            o_idx = op_ridx_ff;
            if (in_range) begin
               o_valid = 1'b1;
               o_key   = rd_key_ff;
               o_class = rd_class_ff;
               o_count = rd_count_ff;
            end
         end
         ksh_pkg::FIN_CLEAR: begin
            used_in  = '0;
            total_in = '0;
         end
         default: begin
         end
      endcase
   end

   // memory ports: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.finish && meta_we) begin
         key_mem[waddr]   <= op_key_ff;
         class_mem[waddr] <= op_cls_ff;
      end
      if (cmd.finish && count_we) begin
         count_mem[waddr] <= wcount;
      end
      if (issue) begin
         rd_key_ff   <= key_mem[rd_addr];
         rd_class_ff <= class_mem[rd_addr];
         rd_count_ff <= count_mem[rd_addr];
         cmp_ptr_ff  <= rd_addr;
      end
   end

   // request latch and first-unknown tracking
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_cls_ff  <= norm_cls;
         op_key_ff  <= (norm_cls == ksh_pkg::CLASS_NAMED) ? req_symbol_key : '0;
         op_ridx_ff <= req_read_index;
      end
      if (cmd.scan_step && rd_vld_ff && !unk_found_ff &&
          (rd_class_ff == ksh_pkg::CLASS_UNKNOWN)) begin
         unk_idx_ff   <= cmp_ptr_ff;
         unk_count_ff <= rd_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         total_ff     <= '0;
         scan_ptr_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         unk_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            scan_ptr_ff  <= '0;
            rd_vld_ff    <= 1'b0;
            unk_found_ff <= 1'b0;
         end else begin
            if (cmd.scan_step || cmd.read_issue) begin
               rd_vld_ff <= issue;
            end
            if (scan_issue) begin
               scan_ptr_ff <= scan_ptr_ff + CNT_W'(1);
            end
            if (cmd.scan_step && rd_vld_ff &&
                (rd_class_ff == ksh_pkg::CLASS_UNKNOWN)) begin
               unk_found_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            used_ff      <= used_in;
            total_ff     <= total_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output word; hold while stalled
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_idx_ff    <= o_idx;
         rsp_evalid_ff <= o_valid;
         rsp_alloc_ff  <= o_alloc;
         rsp_drop_ff   <= o_drop;
         rsp_key_ff    <= o_key;
         rsp_class_ff  <= o_class;
         rsp_count_ff  <= o_count;
         rsp_total_ff  <= total_in;
         rsp_used_ff   <= ksh_pkg::USED_W'(used_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_entry_index   = rsp_idx_ff;
   assign rsp_entry_valid   = rsp_evalid_ff;
   assign rsp_was_allocated = rsp_alloc_ff;
   assign rsp_dropped       = rsp_drop_ff;
   assign rsp_entry_key     = rsp_key_ff;
   assign rsp_entry_class   = rsp_class_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_total_count   = rsp_total_ff;
   assign rsp_entries_used  = rsp_used_ff;

endmodule

// ----- src/ksh_checker.sv -----
`timescale 1ns / 1ps

module ksh_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic                        rsp_entry_valid,
   input logic                        rsp_was_allocated,
   input logic                        rsp_dropped,
   input logic [ksh_pkg::KEY_W-1:0]   rsp_entry_key,
   input logic [ksh_pkg::CLASS_W-1:0] rsp_entry_class,
   input logic [ksh_pkg::COUNT_W-1:0] rsp_entry_count,
   input logic [ksh_pkg::COUNT_W-1:0] rsp_total_count
);

   // a stalled word keeps its count fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_entry_count) &&
                                 $stable(rsp_total_count))
      else $error("stalled result word changed");

   // a dropped sample names no entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dropped |-> !rsp_entry_valid && !rsp_was_allocated)
      else $error("dropped sample reported an entry");

   // a new entry starts at one sample
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_allocated |-> rsp_entry_valid &&
                                         (rsp_entry_count == 32'd1) &&
                                         (rsp_total_count != 32'd0))
      else $error("allocation result inconsistent");

   // no entry means empty entry fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entry_valid |-> (rsp_entry_count == 32'd0) &&
                                        (rsp_entry_key == 64'd0) &&
                                        (rsp_entry_class == 2'd0))
      else $error("entry fields set without an entry");

endmodule

bind keyed_sample_histogram ksh_checker u_ksh_checker (.*);
